/* src/adaptive_first_order_lowpass_defines.svh */
// assertion macros for the adaptive lowpass, clocked on clk_i, off during reset
`ifndef ADAPTIVE_FIRST_ORDER_LOWPASS_DEFINES_SVH
`define ADAPTIVE_FIRST_ORDER_LOWPASS_DEFINES_SVH

// same-cycle implication
`define AFLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aflp check failed");

// next-cycle implication
`define AFLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aflp check failed");

`endif

/* src/aflp_pkg.sv */
`timescale 1ns / 1ps
package aflp_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF   = 16;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 10;

  localparam int unsigned AMP_W     = 16;
  localparam int unsigned RUN_THR_W = 8;
  localparam int unsigned RUN_W     = 9;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [RUN_W-1:0]     RUN_MAX     = '1;
  localparam logic [RUN_W:0]       RUN_STEP    = 10'd1;
  localparam logic [RUN_W:0]       RUN_BONUS   = 10'd5;
  localparam logic                 ADAPT_RST   = 1'b1;
  localparam logic [AMP_W-1:0]     AMP_THR_RST = 16'd8;
  localparam logic [RUN_THR_W-1:0] RUN_THR_RST = 8'd30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADAPT_EN  = 3'd0,
    REG_GAIN_INIT = 3'd1,
    REG_GAIN_BASE = 3'd2,
    REG_GAIN_STEP = 3'd3,
    REG_AMP_THR   = 3'd4,
    REG_RUN_THR   = 3'd5
  } aflp_reg_e;

  typedef struct packed {
    logic                 adaptive_enable;
    logic [AMP_W-1:0]     amp_threshold;
    logic [RUN_THR_W-1:0] run_threshold;
  } aflp_ctrl_cfg_t;

endpackage

/* src/adaptive_first_order_lowpass.sv */
`timescale 1ns / 1ps
// channel    | valid / ready                        | payload
// sample in  | sample_valid_i / sample_ready_o      | sample_i
// filtered   | filtered_valid_o / filtered_ready_i  | filtered_o
// config     | cfg_we_i (no ready)                  | cfg_idx_i, cfg_wdata_i
//
// one item per cycle unless filtered_ready_i stalls; items pass sample_q, then filtered_q
// the gain, run count and previous output feed back through registers, so no item waits on another
// a stalled result holds the input register; a new item is taken while the held one moves on
// reset sets gain to 0.2 in fixed point, previous output, run count and direction to zero
module adaptive_first_order_lowpass
  import aflp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int unsigned GAIN_W         = GAIN_FRAC_BITS + 1,
  parameter int unsigned CFG_W          = (GAIN_W > AMP_W) ? GAIN_W : AMP_W
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  output logic                    filtered_valid_o,
  input  logic                    filtered_ready_i,
  output logic [SAMPLE_WIDTH-1:0] filtered_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i
);

  `include "adaptive_first_order_lowpass_defines.svh"

  localparam int unsigned       GAIN_RST_I = ((2 << GAIN_FRAC_BITS) + 5) / 10;
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(GAIN_RST_I);
  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(1) << GAIN_FRAC_BITS;

  logic                    in_vld_q;
  logic [SAMPLE_WIDTH-1:0] sample_q;
  logic                    out_vld_q;
  logic [SAMPLE_WIDTH-1:0] filtered_q, filtered_d;
  logic                    advance;
  logic                    in_take;
  logic [GAIN_W-1:0]       gain_use;
  logic [GAIN_W-1:0]       gain_base;
  logic [GAIN_W-1:0]       gain_step;
  aflp_ctrl_cfg_t          ctrl;

  assign advance        = in_vld_q && (!out_vld_q || filtered_ready_i);
  assign sample_ready_o = !in_vld_q || advance;
  assign in_take        = sample_valid_i && sample_ready_o;

  aflp_cfg_regs #(
    .GAIN_W   (GAIN_W),
    .CFG_W    (CFG_W),
    .GAIN_RST (GAIN_RST)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_o      (ctrl),
    .gain_base_o (gain_base),
    .gain_step_o (gain_step)
  );

  aflp_gain_ctrl #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .GAIN_W         (GAIN_W),
    .GAIN_RST       (GAIN_RST)
  ) u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .sample_i    (sample_q),
    .prev_i      (filtered_q),
    .ctrl_i      (ctrl),
    .gain_base_i (gain_base),
    .gain_step_i (gain_step),
    .gain_o      (gain_use)
  );

  aflp_filter #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .GAIN_W         (GAIN_W)
  ) u_filter (
    .sample_i   (sample_q),
    .prev_i     (filtered_q),
    .gain_i     (gain_use),
    .filtered_o (filtered_d)
  );

  // the result register doubles as the previous output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      filtered_q <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        filtered_q <= filtered_d;
      end else if (filtered_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
    end
  end

  assign filtered_valid_o = out_vld_q;
  assign filtered_o       = filtered_q;

  `AFLP_ASSERT_NOW(a_gain_max, advance, gain_use <= GAIN_ONE)
  `AFLP_ASSERT_NEXT(a_result_after_advance, advance, out_vld_q)
  `AFLP_ASSERT_NEXT(a_item_kept, in_vld_q && !advance, in_vld_q && $stable(sample_q))

endmodule

/* src/aflp_cfg_regs.sv */
`timescale 1ns / 1ps
module aflp_cfg_regs
  import aflp_pkg::*;
#(
  parameter int unsigned          GAIN_W   = 11,
  parameter int unsigned          CFG_W    = 16,
  parameter logic [GAIN_W-1:0]    GAIN_RST = '0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output aflp_ctrl_cfg_t       ctrl_o,
  output logic [GAIN_W-1:0]    gain_base_o,
  output logic [GAIN_W-1:0]    gain_step_o
);

  aflp_ctrl_cfg_t      ctrl_q;
  logic [GAIN_W-1:0]   gain_base_q;
  logic [GAIN_W-1:0]   gain_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.adaptive_enable <= ADAPT_RST;
      ctrl_q.amp_threshold   <= AMP_THR_RST;
      ctrl_q.run_threshold   <= RUN_THR_RST;
      gain_base_q            <= GAIN_RST;
      gain_step_q            <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (aflp_reg_e'(cfg_idx_i))
        REG_ADAPT_EN:  ctrl_q.adaptive_enable <= cfg_wdata_i[0];
        // initial gain comes from GAIN_RST at reset; writes to this index are ignored
        REG_GAIN_INIT: ;
        REG_GAIN_BASE: gain_base_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_STEP: gain_step_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_AMP_THR:   ctrl_q.amp_threshold <= cfg_wdata_i[AMP_W-1:0];
        REG_RUN_THR:   ctrl_q.run_threshold <= cfg_wdata_i[RUN_THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign ctrl_o      = ctrl_q;
  assign gain_base_o = gain_base_q;
  assign gain_step_o = gain_step_q;

endmodule

/* src/aflp_gain_ctrl.sv */
`timescale 1ns / 1ps
module aflp_gain_ctrl
  import aflp_pkg::*;
#(
  parameter int unsigned       SAMPLE_WIDTH   = 16,
  parameter int unsigned       GAIN_FRAC_BITS = 10,
  parameter int unsigned       GAIN_W         = GAIN_FRAC_BITS + 1,
  parameter logic [GAIN_W-1:0] GAIN_RST       = '0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [SAMPLE_WIDTH-1:0] prev_i,
  input  aflp_ctrl_cfg_t          ctrl_i,
  input  logic [GAIN_W-1:0]       gain_base_i,
  input  logic [GAIN_W-1:0]       gain_step_i,
  output logic [GAIN_W-1:0]       gain_o
);

  localparam int unsigned       SW    = SAMPLE_WIDTH;
  localparam int unsigned       CMP_W = (SW > AMP_W) ? SW : AMP_W;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic              dir_q, dir_d;

  logic signed [SW:0] diff;
  logic signed [SW:0] diff_neg;
  logic [SW-1:0]      mag;
  logic               dir;
  logic               big;
  logic [RUN_W:0]     run_sum;
  logic [RUN_W-1:0]   run_sat;
  logic               run_over;
  logic [GAIN_W:0]    gain_sum;
  logic [GAIN_W-1:0]  gain_up;
  logic [GAIN_W-1:0]  gain_base_c;

  assign diff     = $signed({sample_i[SW-1], sample_i}) - $signed({prev_i[SW-1], prev_i});
  assign diff_neg = -diff;
  assign dir      = !diff[SW] && (diff != '0);
  assign mag      = diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0];
  assign big      = CMP_W'(mag) > CMP_W'(ctrl_i.amp_threshold);

  assign run_sum  = {1'b0, run_q} + (big ? (RUN_STEP + RUN_BONUS) : RUN_STEP);
  assign run_sat  = (run_sum > {1'b0, RUN_MAX}) ? RUN_MAX : run_sum[RUN_W-1:0];
  assign run_over = run_sat > RUN_W'(ctrl_i.run_threshold);

  assign gain_sum    = {1'b0, gain_q} + {1'b0, gain_step_i};
  assign gain_up     = (gain_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_sum[GAIN_W-1:0];
  assign gain_base_c = (gain_base_i > GAIN_ONE) ? GAIN_ONE : gain_base_i;

  always_comb begin
    gain_d = gain_q;
    run_d  = run_q;
    dir_d  = dir_q;
    if (ctrl_i.adaptive_enable) begin
      dir_d = dir;
      if (dir == dir_q) begin
        if (run_over) begin
          gain_d = gain_up;
          run_d  = '0;
        end else begin
          run_d = run_sat;
        end
      end else begin
        gain_d = gain_base_c;
        run_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      run_q  <= '0;
      dir_q  <= 1'b0;
    end else if (advance_i) begin
      gain_q <= gain_d;
      run_q  <= run_d;
      dir_q  <= dir_d;
    end
  end

  assign gain_o = gain_d;

endmodule

/* src/aflp_filter.sv */
`timescale 1ns / 1ps
module aflp_filter
  import aflp_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned GAIN_FRAC_BITS = 10,
  parameter int unsigned GAIN_W         = GAIN_FRAC_BITS + 1
) (
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [SAMPLE_WIDTH-1:0] prev_i,
  input  logic [GAIN_W-1:0]       gain_i,
  output logic [SAMPLE_WIDTH-1:0] filtered_o
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned PW = GAIN_W + SW + 2;

  logic signed [SW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] acc;

  // prev + floor(K * (x - prev) / ONE), same as floor((K*x + (ONE-K)*prev) / ONE)
  assign diff = $signed({sample_i[SW-1], sample_i}) - $signed({prev_i[SW-1], prev_i});
  assign prod = $signed({1'b0, gain_i}) * diff;
  assign acc  = (prod >>> GAIN_FRAC_BITS) + $signed({{(PW-SW){prev_i[SW-1]}}, prev_i});

  assign filtered_o = acc[SW-1:0];

endmodule
